@@ src/nnts_pkg.sv @@
// ============================================================================
// nnts_pkg
// Shared types and constants of the nearest-neighbour texture scaler.
// ============================================================================
package nnts_pkg;

    localparam int STORE_PIXELS_DEF = 65536;
    localparam int MAX_DIM_DEF      = 2048;

    // Internal dimension width covers MAX_DIM up to 4096.
    localparam int DIM_W  = 13;
    // Quotient bits of the coordinate divider (below 2**13 for in-range reads).
    localparam int QW     = 14;
    // Two quotient bits are resolved per divider stage.
    localparam int DIV_STAGES = QW / 2;
    localparam int REM_W  = 28;
    localparam int ADDR_W = 24;
    localparam int PADDR_W = 5;

    // Register indexes (byte address = 4 * index).
    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DEST_WIDTH    = 3'd2;
    localparam logic [2:0] REG_DEST_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd4;
    localparam logic [2:0] REG_AUTO_SIZE     = 3'd5;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [15:0]       load_index;
        logic [31:0]       pixel_in;
        logic [10:0]       dx;
        logic [10:0]       dy;
        logic [DIM_W-1:0]  sw;
        logic [DIM_W-1:0]  sh;
        logic [DIM_W-1:0]  tw;
        logic [DIM_W-1:0]  th;
        logic              fmt;
        logic              needs_scale;
        logic              oor;
        logic [REM_W-1:0]  rem_x;
        logic [REM_W-1:0]  rem_y;
        logic [QW-1:0]     q_x;
        logic [QW-1:0]     q_y;
        logic [DIM_W-1:0]  sx;
        logic [DIM_W-1:0]  sy;
        logic [ADDR_W-1:0] addr;
    } stage_t;

endpackage

@@ src/nnts_in_if.sv @@
// ============================================================================
// nnts_in_if
// Input channel of the scaler: load and read transactions.
// ============================================================================
interface nnts_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] load_index;
    logic [10:0] dest_x;
    logic [10:0] dest_y;
    logic [31:0] pixel_in;

    modport source (output valid, kind, load_index, dest_x, dest_y, pixel_in, input ready);
    modport sink   (input valid, kind, load_index, dest_x, dest_y, pixel_in, output ready);
endinterface

@@ src/nnts_out_if.sv @@
// ============================================================================
// nnts_out_if
// Output channel of the scaler: one sampled pixel per read transaction.
// ============================================================================
interface nnts_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic [10:0] sample_x;
    logic [10:0] sample_y;
    logic [11:0] target_width;
    logic [11:0] target_height;
    logic        needs_scale;
    logic        out_of_range;

    modport source (output valid, pixel_out, sample_x, sample_y, target_width,
                    target_height, needs_scale, out_of_range, input ready);
    modport sink   (input valid, pixel_out, sample_x, sample_y, target_width,
                    target_height, needs_scale, out_of_range, output ready);
endinterface

@@ src/nearest_neighbor_texture_scaler.sv @@
// ============================================================================
// nearest_neighbor_texture_scaler
// Nearest-neighbour resampler with an on-chip source image store.
// ============================================================================
// The block accepts one transaction per clock while the pipeline is not held
// and returns one result per read transaction, in order. Load transactions
// travel down the same pipeline and write the image store at the stage where
// reads fetch it, so a read always sees every load accepted before it. The
// coordinate divider resolves two quotient bits per stage over seven stages.
// In front of it sit a capture stage and a multiply stage. Behind it sit
// clamp, address and store-read stages, which gives twelve register stages in
// all. The whole pipeline advances together. It only holds when a result sits
// in the last stage and the sink is not ready. The image store is not
// cleared: reading a pixel never loaded gives an undefined value.
// The user must write configuration over the APB port only while idle; the
// block itself does not enforce this.
// ============================================================================
module nearest_neighbor_texture_scaler #(
    parameter int STORE_PIXELS = nnts_pkg::STORE_PIXELS_DEF,
    parameter int MAX_DIM      = nnts_pkg::MAX_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nnts_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    nnts_in_if.sink                      in_chan,
    nnts_out_if.source                   out_chan
);

    localparam int AW  = $clog2(STORE_PIXELS);
    localparam int NST = 5 + nnts_pkg::DIV_STAGES;
    localparam int DW  = nnts_pkg::DIM_W;
    localparam logic [DW-1:0] MAX_DIM_V = DW'(MAX_DIM);
    localparam logic [nnts_pkg::ADDR_W-1:0] STORE_V = nnts_pkg::ADDR_W'(STORE_PIXELS);

    // Configuration registers.
    logic [11:0] source_width_reg, source_height_reg, dest_width_reg, dest_height_reg;
    logic        pixel_format_reg, auto_size_reg;

    logic                   cfg_write;
    logic [2:0]             cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= 12'd1;
            source_height_reg <= 12'd1;
            dest_width_reg    <= 12'd1;
            dest_height_reg   <= 12'd1;
            pixel_format_reg  <= 1'b0;
            auto_size_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                nnts_pkg::REG_SOURCE_WIDTH:  source_width_reg  <= pwdata[11:0];
                nnts_pkg::REG_SOURCE_HEIGHT: source_height_reg <= pwdata[11:0];
                nnts_pkg::REG_DEST_WIDTH:    dest_width_reg    <= pwdata[11:0];
                nnts_pkg::REG_DEST_HEIGHT:   dest_height_reg   <= pwdata[11:0];
                nnts_pkg::REG_PIXEL_FORMAT:  pixel_format_reg  <= pwdata[0];
                nnts_pkg::REG_AUTO_SIZE:     auto_size_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            nnts_pkg::REG_SOURCE_WIDTH:  prdata = {20'd0, source_width_reg};
            nnts_pkg::REG_SOURCE_HEIGHT: prdata = {20'd0, source_height_reg};
            nnts_pkg::REG_DEST_WIDTH:    prdata = {20'd0, dest_width_reg};
            nnts_pkg::REG_DEST_HEIGHT:   prdata = {20'd0, dest_height_reg};
            nnts_pkg::REG_PIXEL_FORMAT:  prdata = {31'd0, pixel_format_reg};
            nnts_pkg::REG_AUTO_SIZE:     prdata = {31'd0, auto_size_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // Dimensions above MAX_DIM are taken as MAX_DIM.
    function automatic logic [DW-1:0] sat_dim(logic [11:0] v);
        logic [DW-1:0] w;
        w = DW'(v);
        return (w > MAX_DIM_V) ? MAX_DIM_V : w;
    endfunction

    function automatic logic is_pow2(logic [DW-1:0] v);
        return (v & (v - DW'(1))) == '0;
    endfunction

    // Powers of two pass; else nearest one below MAX_DIM, ties to smaller.
    function automatic logic [DW-1:0] best_size(logic [DW-1:0] v);
        logic [DW:0] lo;
        logic [DW:0] hi;
        logic [DW:0] wv;
        lo = '0;
        wv = {1'b0, v};
        for (int i = 0; i < DW; i++)
        begin
            if (v[i])
                lo = (DW+1)'(1) << i;
        end
        hi = lo << 1;
        if (is_pow2(v))
            return v;
        if (hi < (DW+1)'(MAX_DIM) && (hi - wv) < (wv - lo))
            return hi[DW-1:0];
        return lo[DW-1:0];
    endfunction

    // Two bits of the restoring division of the mapping numerators by 2*target.
    function automatic nnts_pkg::stage_t div_step(nnts_pkg::stage_t s, int k);
        nnts_pkg::stage_t r;
        logic [nnts_pkg::REM_W-1:0] dsx;
        logic [nnts_pkg::REM_W-1:0] dsy;
        int b;
        r = s;
        for (int j = 0; j < 2; j++)
        begin
            b   = nnts_pkg::QW - 1 - 2 * k - j;
            dsx = nnts_pkg::REM_W'({r.tw, 1'b0}) << b;
            dsy = nnts_pkg::REM_W'({r.th, 1'b0}) << b;
            if (r.rem_x >= dsx)
            begin
                r.rem_x  = r.rem_x - dsx;
                r.q_x[b] = 1'b1;
            end
            if (r.rem_y >= dsy)
            begin
                r.rem_y  = r.rem_y - dsy;
                r.q_y[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] clamp(logic [nnts_pkg::QW-1:0] q, logic [DW-1:0] src);
        logic [DW-1:0] last;
        last = (src != '0) ? src - DW'(1) : '0;
        return (nnts_pkg::QW'(last) < q) ? last : q[DW-1:0];
    endfunction

    nnts_pkg::stage_t pipe_reg  [NST];
    nnts_pkg::stage_t pipe_next [NST];
    logic [31:0]      rd_data_reg;
    logic [31:0]      image_mem [STORE_PIXELS];
    logic             advance;

    // Only a waiting result in the last stage holds the pipeline.
    assign advance       = !(pipe_reg[NST-1].valid && pipe_reg[NST-1].kind == nnts_pkg::KIND_READ)
                           || out_chan.ready;
    assign in_chan.ready = advance;

    always_comb
    begin
        logic [DW-1:0] sw;
        logic [DW-1:0] sh;
        nnts_pkg::stage_t s;
        sw = sat_dim(source_width_reg);
        sh = sat_dim(source_height_reg);

        // Stage 0: capture the transaction and the effective sizes.
        s             = '0;
        s.valid       = in_chan.valid;
        s.kind        = in_chan.kind;
        s.load_index  = in_chan.load_index;
        s.pixel_in    = in_chan.pixel_in;
        s.dx          = in_chan.dest_x;
        s.dy          = in_chan.dest_y;
        s.sw          = sw;
        s.sh          = sh;
        s.tw          = auto_size_reg ? best_size(sw) : sat_dim(dest_width_reg);
        s.th          = auto_size_reg ? best_size(sh) : sat_dim(dest_height_reg);
        s.fmt         = pixel_format_reg;
        s.needs_scale = !is_pow2(sw) || !is_pow2(sh);
        s.oor         = (DW'(in_chan.dest_x) >= s.tw) || (DW'(in_chan.dest_y) >= s.th);
        pipe_next[0]  = s;

        // Stage 1: numerators 2*pos*src + dst, halves rounding up.
        s            = pipe_reg[0];
        s.rem_x      = nnts_pkg::REM_W'({s.dx, 1'b0}) * nnts_pkg::REM_W'(s.sw)
                       + nnts_pkg::REM_W'(s.tw);
        s.rem_y      = nnts_pkg::REM_W'({s.dy, 1'b0}) * nnts_pkg::REM_W'(s.sh)
                       + nnts_pkg::REM_W'(s.th);
        s.q_x        = '0;
        s.q_y        = '0;
        pipe_next[1] = s;

        for (int k = 0; k < nnts_pkg::DIV_STAGES; k++)
            pipe_next[2 + k] = div_step(pipe_reg[1 + k], k);

        // Clamp to the last column and row.
        s       = pipe_reg[1 + nnts_pkg::DIV_STAGES];
        s.sx    = clamp(s.q_x, s.sw);
        s.sy    = clamp(s.q_y, s.sh);
        pipe_next[2 + nnts_pkg::DIV_STAGES] = s;

        // Row-major store address.
        s       = pipe_reg[2 + nnts_pkg::DIV_STAGES];
        s.addr  = nnts_pkg::ADDR_W'(s.sy) * nnts_pkg::ADDR_W'(s.sw)
                  + nnts_pkg::ADDR_W'(s.sx);
        pipe_next[3 + nnts_pkg::DIV_STAGES] = s;

        pipe_next[4 + nnts_pkg::DIV_STAGES] = pipe_reg[3 + nnts_pkg::DIV_STAGES];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                pipe_reg[i] <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < NST; i++)
                pipe_reg[i] <= pipe_next[i];
        end
    end

    // Image store: loads write and reads fetch at the same stage, keeping order.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (pipe_reg[NST-2].valid && pipe_reg[NST-2].kind == nnts_pkg::KIND_LOAD
                && nnts_pkg::ADDR_W'(pipe_reg[NST-2].load_index) < STORE_V)
                image_mem[AW'(pipe_reg[NST-2].load_index)] <= pipe_reg[NST-2].pixel_in;
            rd_data_reg <= image_mem[pipe_reg[NST-2].addr[AW-1:0]];
        end
    end

    always_comb
    begin
        logic [31:0] pix;
        pix = (pipe_reg[NST-1].addr < STORE_V) ? rd_data_reg : 32'd0;
        if (pipe_reg[NST-1].fmt)
            pix = pix & 32'h00FF_FFFF;
        if (pipe_reg[NST-1].oor)
            pix = 32'd0;
        out_chan.valid         = pipe_reg[NST-1].valid && pipe_reg[NST-1].kind == nnts_pkg::KIND_READ;
        out_chan.pixel_out     = pix;
        out_chan.sample_x      = pipe_reg[NST-1].oor ? 11'd0 : pipe_reg[NST-1].sx[10:0];
        out_chan.sample_y      = pipe_reg[NST-1].oor ? 11'd0 : pipe_reg[NST-1].sy[10:0];
        out_chan.target_width  = pipe_reg[NST-1].tw[11:0];
        out_chan.target_height = pipe_reg[NST-1].th[11:0];
        out_chan.needs_scale   = pipe_reg[NST-1].needs_scale;
        out_chan.out_of_range  = pipe_reg[NST-1].oor;
    end

endmodule

@@ tb/nearest_neighbor_texture_scaler_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// nearest_neighbor_texture_scaler_tb
// Self-checking testbench of the nearest-neighbour texture scaler.
// ============================================================================
// The configuration port sets up the source and target sizes. The input
// channel then carries load and read transactions. Every read is predicted
// by a model of the scaler held in this file, or given by its row in the
// directed table, and every result is checked field by field against that
// expectation. A short directed table comes first. Randomised phases follow,
// each with its own configuration. The extreme sizes are among them: zero,
// oversized, powers of two, ties in auto sizing and RGB format.
// ============================================================================
module nearest_neighbor_texture_scaler_tb;

    localparam int  STORE      = 65536;
    localparam int  DIM_LIMIT  = 2048;
    localparam int  IDLE_LIMIT = 4000;
    localparam int  PHASES     = 13;
    localparam int  PHASE_ITEMS = 150;

    typedef struct packed {
        logic [31:0] pixel;
        logic [10:0] sx;
        logic [10:0] sy;
        logic [11:0] tw;
        logic [11:0] th;
        logic        ns;
        logic        oor;
    } sample_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] index;
        logic [10:0] x;
        logic [10:0] y;
        logic [31:0] pixel;
        logic        typed;
        sample_t     result;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel, penable, pwrite, pready;
    logic [nnts_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    nnts_in_if  in_if ();
    nnts_out_if out_if ();

    nearest_neighbor_texture_scaler DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_chan  (in_if),
        .out_chan (out_if)
    );

    always #1 clk = ~clk;

    // Shadow copy of the scaler's configuration and image store.
    logic [11:0] cfg_sw, cfg_sh, cfg_dw, cfg_dh;
    logic        cfg_rgb, cfg_auto;
    logic [31:0] image_shadow [STORE];
    bit          loaded [STORE];

    sample_t     pending_samples [$];
    row_t        directed_rows [$];
    int          fail_count = 0;
    int          item_count = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------------
    function automatic int unsigned clamp_dim(input logic [11:0] v);
        return (v > DIM_LIMIT) ? DIM_LIMIT : v;
    endfunction

    // A zero dimension counts as a power of two here, as in the scaler.
    function automatic bit pow2(input int unsigned v);
        return (v & (v - 1)) == 0;
    endfunction

    // Powers of two pass; else nearest one in 2..MAX_DIM/2, ties to smaller.
    function automatic int unsigned auto_dim(input int unsigned v);
        int unsigned best, gap, c, d;
        if (pow2(v))
            return v;
        best = 2;
        gap  = (v > 2) ? v - 2 : 2 - v;
        for (c = 2; c < DIM_LIMIT; c = c << 1)
        begin
            d = (v > c) ? v - c : c - v;
            if (d < gap)
            begin
                best = c;
                gap  = d;
            end
        end
        return best;
    endfunction

    // Exact round(pos*src/dst) with halves up, clamped to the last column/row.
    function automatic int unsigned nearest_src(input int unsigned pos,
                                                input int unsigned src,
                                                input int unsigned dst);
        longint unsigned num, q, last;
        num  = 2 * longint'(pos) * src + dst;
        q    = num / (2 * longint'(dst));
        last = (src != 0) ? src - 1 : 0;
        return 32'((q > last) ? last : q);
    endfunction

    function automatic sample_t predict_sample(input int unsigned x, input int unsigned y,
                                               output longint unsigned addr);
        sample_t r;
        int unsigned sw, sh, tw, th;
        sw = clamp_dim(cfg_sw);
        sh = clamp_dim(cfg_sh);
        tw = cfg_auto ? auto_dim(sw) : clamp_dim(cfg_dw);
        th = cfg_auto ? auto_dim(sh) : clamp_dim(cfg_dh);
        r       = '0;
        addr    = STORE;
        r.tw    = 12'(tw);
        r.th    = 12'(th);
        r.ns    = !pow2(sw) || !pow2(sh);
        r.oor   = (x >= tw) || (y >= th);
        if (!r.oor)
        begin
            r.sx = 11'(nearest_src(x, sw, tw));
            r.sy = 11'(nearest_src(y, sh, th));
            addr = longint'(r.sy) * sw + r.sx;
            if (addr < STORE)
                r.pixel = image_shadow[addr];
            if (cfg_rgb)
                r.pixel[31:24] = 8'h00;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration writes over the APB port.
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            nnts_pkg::REG_SOURCE_WIDTH:  cfg_sw   = value[11:0];
            nnts_pkg::REG_SOURCE_HEIGHT: cfg_sh   = value[11:0];
            nnts_pkg::REG_DEST_WIDTH:    cfg_dw   = value[11:0];
            nnts_pkg::REG_DEST_HEIGHT:   cfg_dh   = value[11:0];
            nnts_pkg::REG_PIXEL_FORMAT:  cfg_rgb  = value[0];
            nnts_pkg::REG_AUTO_SIZE:     cfg_auto = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(input int sw, input int sh, input int dw, input int dh,
                             input bit rgb, input bit auto_on);
        write_register(nnts_pkg::REG_SOURCE_WIDTH, sw);
        write_register(nnts_pkg::REG_SOURCE_HEIGHT, sh);
        write_register(nnts_pkg::REG_DEST_WIDTH, dw);
        write_register(nnts_pkg::REG_DEST_HEIGHT, dh);
        write_register(nnts_pkg::REG_PIXEL_FORMAT, 32'(rgb));
        write_register(nnts_pkg::REG_AUTO_SIZE, 32'(auto_on));
    endtask

    // ------------------------------------------------------------------------
    // Input transactions. The expectation is queued once the scaler has taken
    // the transaction; a typed row supplies its own expected result.
    // ------------------------------------------------------------------------
    task automatic send_transaction(input logic kind, input logic [15:0] index,
                                    input logic [10:0] x, input logic [10:0] y,
                                    input logic [31:0] pixel, input bit typed,
                                    input sample_t typed_result);
        longint unsigned addr;
        sample_t r;
        in_if.valid      <= 1'b1;
        in_if.kind       <= kind;
        in_if.load_index <= index;
        in_if.dest_x     <= x;
        in_if.dest_y     <= y;
        in_if.pixel_in   <= pixel;
        do
            @(posedge clk);
        while (!in_if.ready);
        item_count++;
        if (kind == nnts_pkg::KIND_LOAD)
        begin
            image_shadow[index] = pixel;
            loaded[index]       = 1'b1;
        end
        else
        begin
            r = predict_sample(x, y, addr);
            pending_samples.push_back(typed ? typed_result : r);
        end
        calm = (item_count >= 700) && (item_count < 1000);
        if (!calm && $urandom_range(99) < 20)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // A read that would fetch a never-loaded pixel is preceded by a load of it.
    task automatic read_pixel(input logic [10:0] x, input logic [10:0] y);
        longint unsigned addr;
        sample_t r;
        r = predict_sample(x, y, addr);
        if (!r.oor && addr < STORE && !loaded[addr])
            send_transaction(nnts_pkg::KIND_LOAD, 16'(addr), 11'($urandom), 11'($urandom),
                             $urandom, 1'b0, '0);
        send_transaction(nnts_pkg::KIND_READ, 16'($urandom), x, y, $urandom, 1'b0, '0);
    endtask

    // Wait until every read has come back, then let any trailing loads leave
    // the twelve-stage pipeline before the configuration is touched.
    task automatic drain;
        if (in_if.valid)
            in_if.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure and checking.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                fail_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (out_if.pixel_out !== want.pixel)
                begin
                    $error("pixel_out: expected %h, got %h", want.pixel, out_if.pixel_out);
                    fail_count++;
                end
                if (out_if.sample_x !== want.sx)
                begin
                    $error("sample_x: expected %0d, got %0d", want.sx, out_if.sample_x);
                    fail_count++;
                end
                if (out_if.sample_y !== want.sy)
                begin
                    $error("sample_y: expected %0d, got %0d", want.sy, out_if.sample_y);
                    fail_count++;
                end
                if (out_if.target_width !== want.tw)
                begin
                    $error("target_width: expected %0d, got %0d", want.tw,
                           out_if.target_width);
                    fail_count++;
                end
                if (out_if.target_height !== want.th)
                begin
                    $error("target_height: expected %0d, got %0d", want.th,
                           out_if.target_height);
                    fail_count++;
                end
                if (out_if.needs_scale !== want.ns)
                begin
                    $error("needs_scale: expected %0d, got %0d", want.ns,
                           out_if.needs_scale);
                    fail_count++;
                end
                if (out_if.out_of_range !== want.oor)
                begin
                    $error("out_of_range: expected %0d, got %0d", want.oor,
                           out_if.out_of_range);
                    fail_count++;
                end
            end
        end
        out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
    end

    // Watchdog: any accepted transaction on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("nearest_neighbor_texture_scaler_tb: FAIL");
            $finish;
        end
    end

    task automatic add_row(input logic kind, input logic [15:0] index, input logic [10:0] x,
                           input logic [10:0] y, input logic [31:0] pixel, input bit typed,
                           input sample_t result);
        row_t r;
        r = '{kind, index, x, y, pixel, typed, result};
        directed_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        int sw, sh, dw, dh, tw, th;
        bit rgb, auto_on;
        sample_t none;

        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_if.valid      = 1'b0;
        in_if.kind       = nnts_pkg::KIND_LOAD;
        in_if.load_index = '0;
        in_if.dest_x     = '0;
        in_if.dest_y     = '0;
        in_if.pixel_in   = '0;
        cfg_sw = 1; cfg_sh = 1; cfg_dw = 1; cfg_dh = 1; cfg_rgb = 0; cfg_auto = 0;
        none = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset configuration: a 1x1 source scaled
        // to 1x1, so anything but the origin lies out of range.
        add_row(nnts_pkg::KIND_LOAD, 16'd0, 11'd0, 11'd0, 32'hDEAD_BEEF, 0, none);
        add_row(nnts_pkg::KIND_READ, 16'd0, 11'd0, 11'd0, 32'h0, 1,
                '{32'hDEAD_BEEF, 11'd0, 11'd0, 12'd1, 12'd1, 1'b0, 1'b0});
        add_row(nnts_pkg::KIND_READ, 16'd0, 11'd1, 11'd0, 32'h0, 1,
                '{32'h0, 11'd0, 11'd0, 12'd1, 12'd1, 1'b0, 1'b1});
        add_row(nnts_pkg::KIND_READ, 16'd0, 11'd0, 11'd1, 32'h0, 1,
                '{32'h0, 11'd0, 11'd0, 12'd1, 12'd1, 1'b0, 1'b1});
        add_row(nnts_pkg::KIND_READ, 16'hFFFF, 11'h7FF, 11'h7FF, 32'hFFFF_FFFF, 1,
                '{32'h0, 11'd0, 11'd0, 12'd1, 12'd1, 1'b0, 1'b1});
        add_row(nnts_pkg::KIND_LOAD, 16'hFFFF, 11'h7FF, 11'h7FF, 32'hFFFF_FFFF, 0, none);
        add_row(nnts_pkg::KIND_LOAD, 16'd1, 11'd0, 11'd0, 32'h0000_0000, 0, none);
        add_row(nnts_pkg::KIND_LOAD, 16'd0, 11'd0, 11'd0, 32'hFFFF_FFFF, 0, none);
        add_row(nnts_pkg::KIND_READ, 16'd0, 11'd0, 11'd0, 32'h0, 1,
                '{32'hFFFF_FFFF, 11'd0, 11'd0, 12'd1, 12'd1, 1'b0, 1'b0});
        add_row(nnts_pkg::KIND_LOAD, 16'd0, 11'd0, 11'd0, 32'h0000_0000, 0, none);
        add_row(nnts_pkg::KIND_READ, 16'd0, 11'd0, 11'd0, 32'h0, 1,
                '{32'h0, 11'd0, 11'd0, 12'd1, 12'd1, 1'b0, 1'b0});
        add_row(nnts_pkg::KIND_LOAD, 16'd0, 11'd0, 11'd0, 32'hA5A5_5A5A, 0, none);
        add_row(nnts_pkg::KIND_READ, 16'd0, 11'd0, 11'd0, 32'h0, 0, none);
        foreach (directed_rows[i])
            send_transaction(directed_rows[i].kind, directed_rows[i].index,
                             directed_rows[i].x, directed_rows[i].y,
                             directed_rows[i].pixel, directed_rows[i].typed,
                             directed_rows[i].result);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            // Small images most of the time, so that reads fall on stored
            // pixels; the extreme settings each get a phase of their own.
            sw = $urandom_range(1, 16);
            sh = $urandom_range(1, 16);
            dw = $urandom_range(1, 40);
            dh = $urandom_range(1, 40);
            rgb = $urandom_range(1);
            auto_on = $urandom_range(1);
            case (p)
                0: begin sw = 0;    sh = 0;    auto_on = 0; end
                1: begin sw = 4095; sh = 2048; dw = 2048; dh = 4095; rgb = 1; auto_on = 0; end
                2: begin sw = 3;    sh = 1536; auto_on = 1; end
                3: begin dw = 0;    dh = 0;    auto_on = 0; end
                4: begin sw = 2047; sh = 33;   auto_on = 1; rgb = 0; end
                5: begin sw = 8;    sh = 16;   dw = 4095; dh = 1; auto_on = 0; end
                6: begin sw = 0;    sh = 4095; auto_on = 1; end
                7: begin sw = 12;   sh = 6;    auto_on = 1; rgb = 1; end
                default: ;
            endcase
            configure(sw, sh, dw, dh, rgb, auto_on);
            tw = cfg_auto ? auto_dim(clamp_dim(cfg_sw)) : clamp_dim(cfg_dw);
            th = cfg_auto ? auto_dim(clamp_dim(cfg_sh)) : clamp_dim(cfg_dh);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                int pick;
                pick = $urandom_range(99);
                if (pick < 35)
                    send_transaction(nnts_pkg::KIND_LOAD,
                                     16'($urandom_range(0, (sw * sh > 0 && sw * sh < STORE)
                                                           ? sw * sh - 1 : STORE - 1)),
                                     11'($urandom), 11'($urandom), $urandom, 1'b0, none);
                else if (pick < 40)
                    send_transaction(nnts_pkg::KIND_LOAD, 16'($urandom), 11'($urandom),
                                     11'($urandom), $urandom, 1'b0, none);
                else if (pick < 88 && tw > 0 && th > 0)
                    read_pixel(11'($urandom_range(0, (tw > 2048 ? 2048 : tw) - 1)),
                               11'($urandom_range(0, (th > 2048 ? 2048 : th) - 1)));
                else
                    read_pixel(11'($urandom), 11'($urandom));
            end
            drain();
        end

        if (fail_count == 0)
            $display("nearest_neighbor_texture_scaler_tb: PASS");
        else
            $display("nearest_neighbor_texture_scaler_tb: FAIL");
        $finish;
    end

endmodule
